[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_ON(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[hdl/rap_pkg.sv]
// ----------------------------------------------------------------------------
// rap_pkg
// Shared constants, types and helpers for the RESP array parser.
// ----------------------------------------------------------------------------
package rap_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int LENGTH_BITS = 32;
    localparam int IDX_W       = 16;
    localparam int SUM_W       = LENGTH_BITS + 4;

    localparam logic [2:0] PH_STAR      = 3'd0;
    localparam logic [2:0] PH_COUNT     = 3'd1;
    localparam logic [2:0] PH_COUNT_EOL = 3'd2;
    localparam logic [2:0] PH_DOLLAR    = 3'd3;
    localparam logic [2:0] PH_LEN       = 3'd4;
    localparam logic [2:0] PH_LEN_EOL   = 3'd5;
    localparam logic [2:0] PH_DATA      = 3'd6;
    localparam logic [2:0] PH_TRAIL     = 3'd7;

    localparam logic [1:0] K_DATA = 2'd0;
    localparam logic [1:0] K_END  = 2'd1;
    localparam logic [1:0] K_DONE = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_STAR   = 3'd1;
    localparam logic [2:0] E_COUNT  = 3'd2;
    localparam logic [2:0] E_DOLLAR = 3'd3;
    localparam logic [2:0] E_LENGTH = 3'd4;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [2:0]             phase;
        logic                   digit_seen;
        logic [COUNT_BITS-1:0]  element_total;
        logic [COUNT_BITS-1:0]  element_counter;
        logic [LENGTH_BITS-1:0] bytes_remaining;
    } t_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       out_byte;
        logic [IDX_W-1:0] element_index;
        logic             last_element;
        logic [2:0]       error_code;
    } t_result;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

[hdl/rap_step.sv]
// ----------------------------------------------------------------------------
// rap_step
// Next-state and result logic for one byte of the RESP array stream.
// ----------------------------------------------------------------------------
module rap_step (
    input  rap_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    output rap_pkg::t_state  o_state,
    output logic             o_emit,
    output rap_pkg::t_result o_result
);

    logic                          w_digit;
    logic [3:0]                    w_dval;
    logic [rap_pkg::SUM_W-1:0]     w_sum;
    logic                          w_cnt;
    logic                          w_ovf;
    logic                          w_last;
    logic [rap_pkg::LENGTH_BITS-1:0] w_dec;
    logic [rap_pkg::IDX_W-1:0]     w_idx;

    assign w_digit = (i_byte >= rap_pkg::CH_ZERO) && (i_byte <= rap_pkg::CH_NINE);
    assign w_dval  = 4'(i_byte - rap_pkg::CH_ZERO);
    // acc * 10 + digit as two shifted adds
    assign w_sum   = {1'b0, i_state.bytes_remaining, 3'b000}
                   + {3'b000, i_state.bytes_remaining, 1'b0}
                   + {{(rap_pkg::SUM_W-4){1'b0}}, w_dval};
    assign w_cnt   = (i_state.phase == rap_pkg::PH_COUNT);
    assign w_ovf   = w_cnt ? (|w_sum[rap_pkg::SUM_W-1:rap_pkg::COUNT_BITS])
                           : (|w_sum[rap_pkg::SUM_W-1:rap_pkg::LENGTH_BITS]);
    assign w_last  = (i_state.element_counter
                      == (i_state.element_total - rap_pkg::COUNT_BITS'(1)));
    assign w_dec   = i_state.bytes_remaining - rap_pkg::LENGTH_BITS'(1);
    assign w_idx   = rap_pkg::IDX_W'(i_state.element_counter);

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        unique case (i_state.phase)
            rap_pkg::PH_STAR: begin
                if (!rap_pkg::is_space(i_byte)) begin
                    if (i_byte == rap_pkg::CH_STAR) begin
                        o_state.phase           = rap_pkg::PH_COUNT;
                        o_state.digit_seen      = 1'b0;
                        o_state.bytes_remaining = '0;
                    end else begin
                        o_emit              = 1'b1;
                        o_result.kind       = rap_pkg::K_ERR;
                        o_result.error_code = rap_pkg::E_STAR;
                        o_state.digit_seen      = 1'b0;
                        o_state.bytes_remaining = '0;
                    end
                end
            end
            rap_pkg::PH_COUNT, rap_pkg::PH_LEN: begin
                priority if (w_digit) begin
                    if (w_ovf) begin
                        o_emit                  = 1'b1;
                        o_result.kind           = rap_pkg::K_ERR;
                        o_result.error_code     = w_cnt ? rap_pkg::E_COUNT
                                                        : rap_pkg::E_LENGTH;
                        o_result.element_index  = w_cnt ? '0 : w_idx;
                        o_state.phase           = rap_pkg::PH_STAR;
                        o_state.digit_seen      = 1'b0;
                        o_state.bytes_remaining = '0;
                    end else begin
                        o_state.bytes_remaining = w_sum[rap_pkg::LENGTH_BITS-1:0];
                        o_state.digit_seen      = 1'b1;
                    end
                end else if (!i_state.digit_seen) begin
                    if (!rap_pkg::is_space(i_byte) || (i_byte == rap_pkg::CH_LF)) begin
                        o_emit                  = 1'b1;
                        o_result.kind           = rap_pkg::K_ERR;
                        o_result.error_code     = w_cnt ? rap_pkg::E_COUNT
                                                        : rap_pkg::E_LENGTH;
                        o_result.element_index  = w_cnt ? '0 : w_idx;
                        o_state.phase           = rap_pkg::PH_STAR;
                        o_state.bytes_remaining = '0;
                    end
                end else if (i_byte != rap_pkg::CH_LF) begin
                    o_state.digit_seen = 1'b0;
                    o_state.phase      = w_cnt ? rap_pkg::PH_COUNT_EOL
                                               : rap_pkg::PH_LEN_EOL;
                end else if (w_cnt) begin
                    o_state.digit_seen      = 1'b0;
                    o_state.element_total   =
                        i_state.bytes_remaining[rap_pkg::COUNT_BITS-1:0];
                    o_state.bytes_remaining = '0;
                    o_state.element_counter = '0;
                    if (i_state.bytes_remaining == '0) begin
                        o_state.phase = rap_pkg::PH_STAR;
                        o_emit        = 1'b1;
                        o_result.kind = rap_pkg::K_DONE;
                    end else begin
                        o_state.phase = rap_pkg::PH_DOLLAR;
                    end
                end else begin
                    o_state.digit_seen = 1'b0;
                    o_state.phase = (i_state.bytes_remaining != '0) ? rap_pkg::PH_DATA
                                                                    : rap_pkg::PH_TRAIL;
                end
            end
            rap_pkg::PH_COUNT_EOL: begin
                if (i_byte == rap_pkg::CH_LF) begin
                    o_state.element_total   =
                        i_state.bytes_remaining[rap_pkg::COUNT_BITS-1:0];
                    o_state.bytes_remaining = '0;
                    o_state.element_counter = '0;
                    if (i_state.bytes_remaining == '0) begin
                        o_state.phase = rap_pkg::PH_STAR;
                        o_emit        = 1'b1;
                        o_result.kind = rap_pkg::K_DONE;
                    end else begin
                        o_state.phase = rap_pkg::PH_DOLLAR;
                    end
                end
            end
            rap_pkg::PH_LEN_EOL: begin
                if (i_byte == rap_pkg::CH_LF) begin
                    o_state.phase = (i_state.bytes_remaining != '0) ? rap_pkg::PH_DATA
                                                                    : rap_pkg::PH_TRAIL;
                end
            end
            rap_pkg::PH_DOLLAR: begin
                if (!rap_pkg::is_space(i_byte)) begin
                    o_state.digit_seen      = 1'b0;
                    o_state.bytes_remaining = '0;
                    if (i_byte == rap_pkg::CH_DOLLAR) begin
                        o_state.phase = rap_pkg::PH_LEN;
                    end else begin
                        o_state.phase          = rap_pkg::PH_STAR;
                        o_emit                 = 1'b1;
                        o_result.kind          = rap_pkg::K_ERR;
                        o_result.error_code    = rap_pkg::E_DOLLAR;
                        o_result.element_index = w_idx;
                    end
                end
            end
            rap_pkg::PH_DATA: begin
                o_state.bytes_remaining = w_dec;
                if (w_dec == '0) begin
                    o_state.phase = rap_pkg::PH_TRAIL;
                end
                o_emit                 = 1'b1;
                o_result.kind          = rap_pkg::K_DATA;
                o_result.out_byte      = i_byte;
                o_result.element_index = w_idx;
                o_result.last_element  = w_last;
            end
            rap_pkg::PH_TRAIL: begin
                if (i_byte == rap_pkg::CH_LF) begin
                    o_state.element_counter = i_state.element_counter
                                            + rap_pkg::COUNT_BITS'(1);
                    o_state.phase           = w_last ? rap_pkg::PH_STAR
                                                     : rap_pkg::PH_DOLLAR;
                    o_emit                  = 1'b1;
                    o_result.kind           = rap_pkg::K_END;
                    o_result.element_index  = w_idx;
                    o_result.last_element   = w_last;
                end
            end
        endcase
    end

endmodule

[hdl/resp_array_parser.sv]
// ----------------------------------------------------------------------------
// resp_array_parser
// Byte-serial parser for an array of bulk strings, one byte per beat.
// Throughput: one input beat per cycle; input stalls only while a result is held.
// Each byte is held in the input register, then its result in the result register.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to waiting for the array marker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module resp_array_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [23:8] element_index,
                                        // [26:24] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_element
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    rap_pkg::t_result r_out;
    rap_pkg::t_state  r_state;

    rap_pkg::t_state  n_state;
    rap_pkg::t_result w_result;
    logic             w_emit;
    logic             w_advance;

    rap_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: rap_pkg::PH_STAR, default: '0};
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_state     <= n_state;
                r_out_valid <= w_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out.error_code, r_out.element_index, r_out.out_byte};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last_element;

    `ASSERT_ON(a_err_has_code,
        (r_out_valid && (r_out.kind == rap_pkg::K_ERR)) |-> (r_out.error_code != rap_pkg::E_NONE),
        "error beat without error code")
    `ASSERT_ON(a_code_only_on_err,
        (r_out_valid && (r_out.kind != rap_pkg::K_ERR)) |-> (r_out.error_code == rap_pkg::E_NONE),
        "error code on non-error beat")
    `ASSERT_ON(a_byte_only_on_data,
        (r_out_valid && (r_out.kind != rap_pkg::K_DATA)) |-> (r_out.out_byte == 8'h00),
        "payload byte on non-data beat")
    `ASSERT_ON(a_data_has_bytes,
        (r_state.phase == rap_pkg::PH_DATA) |-> (r_state.bytes_remaining != '0),
        "data phase with no bytes left")
    `ASSERT_ON(a_in_held,
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)),
        "pending input byte lost")
    `ASSERT_ALWAYS(a_reset_phase,
        (!i_rst_n) |=> ((r_state.phase == rap_pkg::PH_STAR) && !r_out_valid),
        "parser not idle after reset")

endmodule
